FILE: sv/registration_reply_builder_macros.svh
// Assertion macros shared by the registration reply builder modules.
// Each use expects signals named clock and reset in the enclosing scope.
`ifndef REGISTRATION_REPLY_BUILDER_MACROS_SVH
`define REGISTRATION_REPLY_BUILDER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RRB_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rrb assertion failed");

// Antecedent implies consequent in the next cycle.
`define RRB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rrb assertion failed");

`endif

FILE: sv/rrb_pkg.sv
// Package of the registration reply builder: sizes, codes, the job type
// and the one's complement helpers. Depends on nothing.
package rrb_pkg;

   localparam int FIFO_DEPTH  = 16;
   localparam int MAX_WORDS   = 512;
   localparam int AGENT_SLOTS = 4;

   localparam int WORD_W    = 32;
   localparam int POS_W     = $clog2(MAX_WORDS + 1);
   localparam int FPTR_W    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FCNT_W    = $clog2(FIFO_DEPTH + 1);
   localparam int ENTRY_W   = 96;
   localparam int CSR_IDX_W = 3;

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;
   localparam int QCNT_W  = 3;

   localparam int PAYLOAD_WORDS = 5;
   localparam int BEAT_W        = 3;
   localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(PAYLOAD_WORDS - 1);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_MAX_LIFETIME = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AGENT_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AGENT_A      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AGENT_B      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AGENT_C      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AGENT_D      = 3'd5;

   localparam logic [15:0] LIFETIME_RESET = 16'd1800;

   // Reply codes.
   localparam logic [7:0] REPLY_TYPE     = 8'd3;
   localparam logic [7:0] CODE_ACCEPT    = 8'd1;
   localparam logic [7:0] CODE_BAD_AGENT = 8'd136;
   localparam logic [7:0] CODE_RESERVED  = 8'd134;
   localparam int         RESERVED_BIT   = 2;

   // Word positions within a packet.
   localparam logic [POS_W-1:0] POS_PROTO    = POS_W'(2);
   localparam logic [POS_W-1:0] POS_SRC      = POS_W'(3);
   localparam logic [POS_W-1:0] POS_DST      = POS_W'(4);
   localparam logic [POS_W-1:0] POS_PORTS    = POS_W'(5);
   localparam logic [POS_W-1:0] POS_UDP_LEN  = POS_W'(6);
   localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(7);
   localparam logic [POS_W-1:0] POS_HOME     = POS_W'(8);
   localparam logic [POS_W-1:0] POS_AGENT    = POS_W'(9);
   localparam logic [POS_W-1:0] POS_ID_HI    = POS_W'(11);
   localparam logic [POS_W-1:0] POS_ID_LO    = POS_W'(12);
   localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(MAX_WORDS);

   typedef struct packed {
      logic                                payload;
      logic                                fault;
      logic                                last;
      logic [PAYLOAD_WORDS-1:0][WORD_W-1:0] words;
   } job_type;

   // End-around carry fold of a sum of up to sixteen 16-bit terms.
   function automatic logic [15:0] oc_fold(input logic [19:0] x);
      logic [16:0] t;
      logic [16:0] r;
      t = 17'(x[15:0]) + 17'(x[19:16]);
      r = 17'(t[15:0]) + 17'(t[16]);
      return r[15:0];
   endfunction

   // One 16-bit half at UDP byte offset h, masked to the UDP length.
   function automatic logic [15:0] half_term(input logic [15:0] v, input logic [16:0] h,
                                             input logic [15:0] ulen);
      logic [15:0] r;
      if ((18'(h) + 18'd1) < 18'(ulen)) begin
         r = v;
      end else if (h < 17'(ulen)) begin
         r = {v[15:8], 8'h00};
      end else begin
         r = 16'h0000;
      end
      return r;
   endfunction

   function automatic logic [16:0] word_terms(input logic [31:0] w, input logic [16:0] off,
                                              input logic [15:0] ulen);
      return 17'(half_term(w[31:16], off, ulen)) +
             17'(half_term(w[15:0], off + 17'd2, ulen));
   endfunction

endpackage

FILE: sv/rrb_ifs.sv
// Valid/ready channel interfaces of the registration reply builder.
// Depends on rrb_pkg for the field widths.
interface rrb_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [rrb_pkg::WORD_W-1:0]   pkt_word;
   logic                         pkt_last;
   modport source (output valid, req_type, pkt_word, pkt_last, input ready);
   modport sink   (input valid, req_type, pkt_word, pkt_last, output ready);
endinterface

interface rrb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         out_port;
   logic [rrb_pkg::WORD_W-1:0]   out_word;
   logic                         out_last;
   logic                         queue_fault;
   modport source (output valid, out_port, out_word, out_last, queue_fault, input ready);
   modport sink   (input valid, out_port, out_word, out_last, queue_fault, output ready);
endinterface

interface rrb_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rrb_pkg::CSR_IDX_W-1:0] index;
   logic [rrb_pkg::WORD_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/registration_reply_builder.sv
// Top level of the registration reply builder: front end, job queue, back end.
// Depends on rrb_pkg, rrb_ifs, rrb_front, rrb_queue and rrb_back.
//
//   Channel   Direction  Carries
//   req_ch    in         req_type, pkt_word, pkt_last: one packet word per item
//   rsp_ch    out        out_port, out_word, out_last, queue_fault
//   csr_ch    in         index, data: one register write per item, always ready
//
// The front end takes one packet word per cycle while the job queue has room; the
// checksummed words join a running one's complement sum, so a request is judged on
// its last word. A good request yields five result items; a framed reply word is
// held in a queue slot and yields one item in the cycle after it leaves the queue.
// A four-entry job queue sits between the two halves; the input stalls only when it fills.
// Reset is synchronous and active high; the pending request store needs no clearing.
module registration_reply_builder (
   input  logic       clock,
   input  logic       reset,
   rrb_req_if.sink    req_ch,
   rrb_rsp_if.source  rsp_ch,
   rrb_csr_if.sink    csr_ch
);
   import rrb_pkg::*;

   // Jobs handed from the front end to the queue.
   logic    q_push;
   job_type q_job;
   logic    q_not_full;

   // Jobs taken by the back end from the queue head.
   logic    q_pop;
   logic    q_head_valid;
   job_type q_head_job;

   rrb_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .csr     (csr_ch),
      .q_ready (q_not_full),
      .q_push  (q_push),
      .q_job   (q_job)
   );

   rrb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .not_full   (q_not_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_job   (q_head_job)
   );

   // The back end owns the output register; a waiting result holds intake back
   // only once the job queue has filled up behind it.
   rrb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_head_valid),
      .job       (q_head_job),
      .job_pop   (q_pop),
      .rsp       (rsp_ch)
   );
endmodule

FILE: sv/rrb_front.sv
// Front end: takes packet words, keeps the checksum, the pending request
// FIFO and the configuration registers, and hands jobs to the queue. Uses rrb_pkg.
module rrb_front (
   input  logic              clock,
   input  logic              reset,
   rrb_req_if.sink           req,
   rrb_csr_if.sink           csr,
   input  logic              q_ready,
   output logic              q_push,
   output rrb_pkg::job_type  q_job
);
   import rrb_pkg::*;

   logic [15:0]        max_life_ff;
   logic [2:0]         agent_cnt_ff;
   logic [WORD_W-1:0]  agent_ff [AGENT_SLOTS];

   logic [ENTRY_W-1:0] mem [FIFO_DEPTH];
   logic [FPTR_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [FCNT_W-1:0]  count_ff, count_in;
   logic               pop, push_entry;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               kind_ff, kind_in, kind_now;
   logic               fault_ff, fault_in, fault_now;
   logic [15:0]        sum_ff, sum_in;
   logic [WORD_W-1:0]  hdr0_ff, hdr0_in, hdr1_ff, hdr1_in, hdr2_ff, hdr2_in;
   logic [15:0]        ulen_ff, ulen_in, csum_ff, csum_in;
   logic [WORD_W-1:0]  rf_ff [PAYLOAD_WORDS];
   logic [WORD_W-1:0]  rf_in [PAYLOAD_WORDS];
   logic [ENTRY_W-1:0] popped_ff;

   logic               accept;
   logic [WORD_W-1:0]  w;
   logic [16:0]        off;
   logic [WORD_W-1:0]  o;
   logic               known;
   logic [2:0]         n_agents;
   logic [7:0]         code;
   logic [15:0]        life;

   assign req.ready = q_ready;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && q_ready;
   assign w         = req.pkt_word;
   assign off       = 17'((17'(pos_ff) - 17'd5) << 2);

   function automatic logic [FPTR_W-1:0] wrap_inc(input logic [FPTR_W-1:0] p);
      return (p == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      n_agents = (agent_cnt_ff > 3'(AGENT_SLOTS)) ? 3'(AGENT_SLOTS) : agent_cnt_ff;
      known    = 1'b0;
      for (int i = 0; i < AGENT_SLOTS; i++) begin
         if ((3'(i) < n_agents) && (agent_ff[i] == rf_in[2])) begin
            known = 1'b1;
         end
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      kind_in    = kind_ff;
      fault_in   = fault_ff;
      sum_in     = sum_ff;
      hdr0_in    = hdr0_ff;
      hdr1_in    = hdr1_ff;
      hdr2_in    = hdr2_ff;
      ulen_in    = ulen_ff;
      csum_in    = csum_ff;
      rf_in      = rf_ff;
      pop        = 1'b0;
      push_entry = 1'b0;
      q_push     = 1'b0;
      q_job      = '0;
      fault_now  = fault_ff;
      o          = w;
      code       = CODE_ACCEPT;
      life       = rf_ff[0][15:0];
      kind_now   = (pos_ff == '0) ? req.req_type : kind_ff;

      if (accept) begin
         if (pos_ff == '0) kind_in = req.req_type;
         if (req.pkt_last) pos_in = '0;
         else if (pos_ff < POS_LIMIT) pos_in = pos_ff + 1'b1;

         if (kind_now) begin
            if (pos_ff == '0) begin
               if (count_ff != '0) begin
                  pop       = 1'b1;
                  fault_now = 1'b0;
               end else begin
                  fault_now = 1'b1;
               end
               fault_in = fault_now;
            end
            if (!fault_now) begin
               if (pos_ff == POS_SRC) o = popped_ff[63:32];
               else if (pos_ff == POS_DST) o = popped_ff[95:64];
               else if (pos_ff == POS_PORTS) o = {popped_ff[15:0], popped_ff[31:16]};
            end
            q_push         = 1'b1;
            q_job.payload  = 1'b0;
            q_job.fault    = fault_now;
            q_job.last     = req.pkt_last;
            q_job.words[0] = o;
         end else begin
            if (pos_ff == '0) begin
               sum_in = '0;
            end else if (pos_ff == POS_PROTO) begin
               // The protocol byte of the pseudo-header joins the sum right away.
               sum_in   = oc_fold(20'(sum_ff) + 20'(w[23:16]));
            end else if (pos_ff == POS_SRC) begin
               hdr0_in = w;
               sum_in  = oc_fold(20'(sum_ff) + 20'(w[31:16]) + 20'(w[15:0]));
            end else if (pos_ff == POS_DST) begin
               hdr1_in = w;
               sum_in  = oc_fold(20'(sum_ff) + 20'(w[31:16]) + 20'(w[15:0]));
            end else if (pos_ff == POS_PORTS) begin
               hdr2_in = w;
            end else if (pos_ff == POS_UDP_LEN) begin
               // Pseudo-header length and the UDP header itself join the sum here.
               ulen_in = w[31:16];
               csum_in = w[15:0];
               sum_in  = oc_fold(20'(sum_ff) + 20'(word_terms(hdr2_ff, 17'd0, w[31:16])) +
                                 20'(word_terms(w, 17'd4, w[31:16])) + 20'(w[31:16]));
            end else if (pos_ff < POS_LIMIT) begin
               sum_in = oc_fold(20'(sum_ff) + 20'(word_terms(w, off, ulen_ff)));
               if (pos_ff == POS_TYPE) rf_in[0] = w;
               else if (pos_ff == POS_HOME) rf_in[1] = w;
               else if (pos_ff == POS_AGENT) rf_in[2] = w;
               else if (pos_ff == POS_ID_HI) rf_in[3] = w;
               else if (pos_ff == POS_ID_LO) rf_in[4] = w;
            end

            life = (rf_in[0][15:0] > max_life_ff) ? max_life_ff : rf_in[0][15:0];
            if (rf_in[0][16 + RESERVED_BIT]) code = CODE_RESERVED;
            else if (!known) code = CODE_BAD_AGENT;

            if (req.pkt_last && (pos_ff >= POS_ID_LO) &&
                ((csum_ff == '0) || (sum_in == 16'hFFFF)) &&
                (count_ff < FCNT_W'(FIFO_DEPTH))) begin
               push_entry     = 1'b1;
               q_push         = 1'b1;
               q_job.payload  = 1'b1;
               q_job.fault    = 1'b0;
               q_job.last     = 1'b1;
               q_job.words[0] = {REPLY_TYPE, code, life};
               q_job.words[1] = rf_in[1];
               q_job.words[2] = rf_in[2];
               q_job.words[3] = rf_in[3];
               q_job.words[4] = rf_in[4];
            end
         end
      end

      head_in  = pop ? wrap_inc(head_ff) : head_ff;
      tail_in  = push_entry ? wrap_inc(tail_ff) : tail_ff;
      count_in = count_ff + FCNT_W'(push_entry) - FCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_entry) mem[tail_ff] <= {hdr0_ff, hdr1_ff, hdr2_ff};
      if (pop) popped_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_life_ff  <= LIFETIME_RESET;
         agent_cnt_ff <= '0;
         for (int i = 0; i < AGENT_SLOTS; i++) agent_ff[i] <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
         kind_ff  <= 1'b0;
         fault_ff <= 1'b0;
         sum_ff   <= '0;
         hdr0_ff  <= '0;
         hdr1_ff  <= '0;
         hdr2_ff  <= '0;
         ulen_ff  <= '0;
         csum_ff  <= '0;
         for (int i = 0; i < PAYLOAD_WORDS; i++) rf_ff[i] <= '0;
      end else begin
         if (csr.valid) begin
            unique case (csr.index)
               REG_MAX_LIFETIME: max_life_ff <= csr.data[15:0];
               REG_AGENT_COUNT:  agent_cnt_ff <= csr.data[2:0];
               REG_AGENT_A:      agent_ff[0] <= csr.data;
               REG_AGENT_B:      if (AGENT_SLOTS > 1) agent_ff[1 % AGENT_SLOTS] <= csr.data;
               REG_AGENT_C:      if (AGENT_SLOTS > 2) agent_ff[2 % AGENT_SLOTS] <= csr.data;
               REG_AGENT_D:      if (AGENT_SLOTS > 3) agent_ff[3 % AGENT_SLOTS] <= csr.data;
               default: ;
            endcase
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         kind_ff  <= kind_in;
         fault_ff <= fault_in;
         sum_ff   <= sum_in;
         hdr0_ff  <= hdr0_in;
         hdr1_ff  <= hdr1_in;
         hdr2_ff  <= hdr2_in;
         ulen_ff  <= ulen_in;
         csum_ff  <= csum_in;
         rf_ff    <= rf_in;
      end
   end

   `include "registration_reply_builder_macros.svh"

   `RRB_ASSERT_SAME(a_fifo_bound, 1'b1, count_ff <= FCNT_W'(FIFO_DEPTH))
   `RRB_ASSERT_NEXT(a_pop_counts, pop, count_ff == $past(count_ff) - 1'b1)
   `RRB_ASSERT_NEXT(a_push_counts, push_entry, count_ff == $past(count_ff) + 1'b1)
endmodule

FILE: sv/rrb_queue.sv
// Short job queue between the front end and the back end.
// Uses rrb_pkg for the job type and its depth.
module rrb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rrb_pkg::job_type  push_job,
   output logic              not_full,
   input  logic              pop,
   output logic              head_valid,
   output rrb_pkg::job_type  head_job
);
   import rrb_pkg::*;

   job_type            slot [QDEPTH];
   logic [QPTR_W-1:0]  rd_ff, wr_ff;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   assign not_full   = cnt_ff < QCNT_W'(QDEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_job   = slot[rd_ff];
   assign cnt_in     = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push) slot[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   `include "registration_reply_builder_macros.svh"

   `RRB_ASSERT_SAME(a_q_bound, 1'b1, cnt_ff <= QCNT_W'(QDEPTH))
   `RRB_ASSERT_SAME(a_q_no_underflow, pop, head_valid)
   `RRB_ASSERT_SAME(a_q_no_overflow, push, not_full)
endmodule

FILE: sv/rrb_back.sv
// Back end: turns queued jobs into result items, five for a reply payload,
// one for a passed framed word, through a registered output. Uses rrb_pkg.
module rrb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  rrb_pkg::job_type  job,
   output logic              job_pop,
   rrb_rsp_if.source         rsp
);
   import rrb_pkg::*;

   logic               valid_ff;
   logic [BEAT_W-1:0]  beat_ff, beat_in;
   logic               port_ff, last_ff, fault_ff;
   logic [WORD_W-1:0]  word_ff;
   logic               load;

   assign load    = job_valid && (!valid_ff || rsp.ready);
   assign job_pop = load && (!job.payload || (beat_ff == LAST_BEAT));

   always_comb begin
      beat_in = beat_ff;
      if (load) beat_in = job_pop ? '0 : beat_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         port_ff  <= !job.payload;
         fault_ff <= job.fault;
         if (job.payload) begin
            word_ff <= job.words[beat_ff];
            last_ff <= beat_ff == LAST_BEAT;
         end else begin
            word_ff <= job.words[0];
            last_ff <= job.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         if (load) valid_ff <= 1'b1;
         else if (rsp.ready) valid_ff <= 1'b0;
         beat_ff <= beat_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.out_port    = port_ff;
   assign rsp.out_word    = word_ff;
   assign rsp.out_last    = last_ff;
   assign rsp.queue_fault = fault_ff;
endmodule

FILE: tb/registration_reply_builder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the registration reply builder.
// Depends on rrb_pkg, the channel interfaces in rrb_ifs and the block itself.
module registration_reply_builder_tb;
   import rrb_pkg::*;

   // Register indexes past the end of the list; writes there must be ignored.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 20;

   typedef enum int {SUM_GOOD, SUM_BAD, SUM_NONE, SUM_ODD_LEN} sum_mode_type;

   // One packet of the stimulus. A nonzero typed_head is the known first
   // payload word of the reply that the request must produce.
   typedef struct {
      bit           is_reply;
      int           nwords;
      bit [7:0]     flags;
      bit [15:0]    life;
      int           agent_sel;
      sum_mode_type mode;
      bit           mix_type;
      bit [31:0]    typed_head;
   } packet_desc_type;

   typedef struct {
      bit          port;
      bit [31:0]   word;
      bit          last;
      bit          fault;
   } reply_item_type;

   logic clock;
   logic reset;

   rrb_req_if req_ch ();
   rrb_rsp_if rsp_ch ();
   rrb_csr_if csr_ch ();

   registration_reply_builder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // Home agent state as the predictor sees it.
   bit [15:0]   lifetime_cap;
   bit [2:0]    agents_valid;
   bit [31:0]   agent_addr [AGENT_SLOTS];
   bit [31:0]   store_src [FIFO_DEPTH];
   bit [31:0]   store_dst [FIFO_DEPTH];
   bit [31:0]   store_ports [FIFO_DEPTH];
   int unsigned store_head;
   int unsigned store_count;
   int unsigned word_pos;
   int unsigned udp_sum;
   bit [31:0]   seen_src, seen_dst, seen_ports;
   bit [15:0]   seen_udp_len;
   bit [15:0]   seen_csum;
   bit [7:0]    seen_proto;
   bit [31:0]   reg_request [5];
   bit [31:0]   pop_src, pop_dst, pop_ports;
   bit          pkt_is_reply;
   bit          reply_unmatched;

   // A nonzero value replaces the predicted first payload word of the next reply.
   bit [31:0]   typed_first;
   // Number of result items that the latest predicted word caused.
   int          step_results;

   reply_item_type pending_replies[$];
   int          mismatches;
   int          words_sent;

   task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
      mismatches++;
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // One's complement arithmetic used both to judge requests and to build
   // requests with a correct checksum.
   // ---------------------------------------------------------------------
   function automatic int unsigned fold_add(int unsigned s, int unsigned v);
      s = s + (v & 32'hFFFF);
      return (s & 32'hFFFF) + (s >> 16);
   endfunction

   // Adds a word at UDP byte offset off; bytes past the UDP length are masked.
   function automatic int unsigned add_udp_word(int unsigned s, bit [31:0] w,
                                                int unsigned off, int unsigned ulen);
      int unsigned h;
      int unsigned v;
      for (int k = 0; k < 2; k++) begin
         h = off + 2 * k;
         v = (k == 0) ? w[31:16] : w[15:0];
         if (h + 1 < ulen)
            s = fold_add(s, v);
         else if (h < ulen)
            s = fold_add(s, v & 32'hFF00);
      end
      return s;
   endfunction

   function automatic int unsigned add_pseudo(int unsigned s, bit [31:0] src, bit [31:0] dst,
                                              bit [7:0] proto, bit [15:0] ulen);
      s = fold_add(s, src[31:16]);
      s = fold_add(s, src[15:0]);
      s = fold_add(s, dst[31:16]);
      s = fold_add(s, dst[15:0]);
      s = fold_add(s, proto);
      return fold_add(s, ulen);
   endfunction

   function automatic bit home_agent_known(bit [31:0] addr);
      int n;
      n = (agents_valid > AGENT_SLOTS) ? AGENT_SLOTS : agents_valid;
      for (int i = 0; i < n; i++)
         if (agent_addr[i] == addr)
            return 1'b1;
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Predictor: advances the home agent state by one accepted packet word and
   // queues the result items it causes.
   // ---------------------------------------------------------------------
   task automatic home_agent_step(bit word_type, bit [31:0] w, bit last);
      int unsigned pos;
      int unsigned tail;
      int unsigned s;
      bit [31:0]   o;
      bit [15:0]   life;
      bit [7:0]    flags;
      bit [7:0]    code;
      bit [31:0]   payload [5];
      reply_item_type it;
      pos = word_pos;
      step_results = 0;
      if (pos == 0)
         pkt_is_reply = word_type;
      if (pkt_is_reply) begin
         o = w;
         if (pos == 0) begin
            if (store_count > 0) begin
               pop_src   = store_src[store_head];
               pop_dst   = store_dst[store_head];
               pop_ports = store_ports[store_head];
               store_head = (store_head + 1) % FIFO_DEPTH;
               store_count--;
               reply_unmatched = 1'b0;
            end else begin
               reply_unmatched = 1'b1;
            end
         end
         // The reply goes back the way the request came: addresses and
         // ports are swapped.
         if (!reply_unmatched) begin
            if (pos == 3)
               o = pop_dst;
            else if (pos == 4)
               o = pop_src;
            else if (pos == 5)
               o = {pop_ports[15:0], pop_ports[31:16]};
         end
         it.port = 1'b1; it.word = o; it.last = last; it.fault = reply_unmatched;
         pending_replies = {pending_replies, it};
         step_results = 1;
      end else begin
         if (pos == 0)
            udp_sum = 0;
         if (pos == 2)
            seen_proto = w[23:16];
         else if (pos == 3)
            seen_src = w;
         else if (pos == 4)
            seen_dst = w;
         else if (pos == 5)
            seen_ports = w;
         else if (pos == 6) begin
            seen_udp_len = w[31:16];
            seen_csum    = w[15:0];
            udp_sum = add_udp_word(udp_sum, seen_ports, 0, seen_udp_len);
            udp_sum = add_udp_word(udp_sum, w, 4, seen_udp_len);
         end else if (pos >= 7 && pos < MAX_WORDS) begin
            udp_sum = add_udp_word(udp_sum, w, (pos - 5) * 4, seen_udp_len);
            if (pos <= 9)
               reg_request[pos - 7] = w;
            else if (pos == 11 || pos == 12)
               reg_request[pos - 8] = w;
         end
         s = add_pseudo(udp_sum, seen_src, seen_dst, seen_proto, seen_udp_len);
         if (last && pos >= 12 && (seen_csum == 0 || s == 32'hFFFF)
             && store_count < FIFO_DEPTH) begin
            tail = (store_head + store_count) % FIFO_DEPTH;
            store_src[tail]   = seen_src;
            store_dst[tail]   = seen_dst;
            store_ports[tail] = seen_ports;
            store_count++;
            life  = reg_request[0][15:0];
            flags = reg_request[0][23:16];
            code  = CODE_ACCEPT;
            if (!home_agent_known(reg_request[2]))
               code = CODE_BAD_AGENT;
            // The reserved flag wins over an unknown home agent.
            if (flags[RESERVED_BIT])
               code = CODE_RESERVED;
            if (life > lifetime_cap)
               life = lifetime_cap;
            payload[0] = (typed_first != 0) ? typed_first : {REPLY_TYPE, code, life};
            payload[1] = reg_request[1];
            payload[2] = reg_request[2];
            payload[3] = reg_request[3];
            payload[4] = reg_request[4];
            for (int k = 0; k < 5; k++) begin
               it.port = 1'b0; it.word = payload[k]; it.last = (k == 4); it.fault = 1'b0;
               pending_replies = {pending_replies, it};
            end
            step_results = 5;
         end
      end
      if (last)
         word_pos = 0;
      else if (pos < MAX_WORDS)
         word_pos = pos + 1;
   endtask

   task automatic apply_register(bit [CSR_IDX_W-1:0] idx, bit [31:0] data);
      case (idx)
         REG_MAX_LIFETIME: lifetime_cap = data[15:0];
         REG_AGENT_COUNT:  agents_valid = data[2:0];
         REG_AGENT_A:      agent_addr[0] = data;
         REG_AGENT_B:      agent_addr[1] = data;
         REG_AGENT_C:      agent_addr[2] = data;
         REG_AGENT_D:      agent_addr[3] = data;
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Drivers. Inputs change only with nonblocking assignments at the clock
   // edge; an item counts as accepted at an edge where valid and ready were
   // both high.
   // ---------------------------------------------------------------------
   task automatic send_word(bit word_type, bit [31:0] w, bit last);
      int gap;
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= word_type;
      req_ch.pkt_word <= w;
      req_ch.pkt_last <= last;
      do @(posedge clock); while (!req_ch.ready);
      home_agent_step(word_type, w, last);
      words_sent++;
      // Mostly back to back, sometimes a short gap, now and then a long one.
      gap = $urandom_range(0, 99);
      if (gap >= 65) begin
         req_ch.valid <= 1'b0;
         repeat ((gap >= 96) ? $urandom_range(10, 30) : $urandom_range(1, 3))
            @(posedge clock);
      end
   endtask

   // Lowers the request valid and waits until every expected item has come,
   // plus a settling wait of SETTLE_CYCLES for a dropped request still in flight.
   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(bit [CSR_IDX_W-1:0] idx, bit [31:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      apply_register(idx, data);
   endtask

   task automatic load_settings(bit [15:0] cap, bit [2:0] cnt, bit [31:0] a, bit [31:0] b,
                                bit [31:0] c, bit [31:0] d);
      wait_quiet();
      write_reg(REG_MAX_LIFETIME, {16'($urandom_range(0, 65535)), cap});
      write_reg(REG_AGENT_COUNT, {29'($urandom), cnt});
      write_reg(REG_AGENT_A, a);
      write_reg(REG_AGENT_B, b);
      write_reg(REG_AGENT_C, c);
      write_reg(REG_AGENT_D, d);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Builds one packet from its description and sends it word by word.
   task automatic send_packet(packet_desc_type pd);
      bit [31:0]   pkt [$];
      bit [31:0]   agent;
      bit [15:0]   ulen;
      bit [15:0]   csum;
      int unsigned s;
      int          n;
      bit          t;
      n = pd.nwords;
      pkt.delete();
      for (int i = 0; i < n; i++)
         pkt = {pkt, 32'($urandom)};
      if (!pd.is_reply && n >= 7) begin
         ulen = 16'((n - 5) * 4);
         if (pd.mode == SUM_ODD_LEN)
            ulen = ($urandom_range(0, 1) != 0) ? ulen - 16'($urandom_range(1, 3))
                                               : ulen + 16'($urandom_range(1, 9));
         pkt[0] = {16'h4500, 16'((n * 4) & 16'hFFFF)};
         pkt[2][23:16] = 8'd17;
         if (n > 7)
            pkt[7] = {8'd1, pd.flags, pd.life};
         if (n > 9) begin
            agent = (pd.agent_sel == 0) ? $urandom : agent_addr[pd.agent_sel - 1];
            pkt[9] = agent;
         end
         pkt[6] = {ulen, 16'h0000};
         s = add_udp_word(0, pkt[5], 0, ulen);
         s = add_udp_word(s, pkt[6], 4, ulen);
         for (int p = 7; p < n && p < MAX_WORDS; p++)
            s = add_udp_word(s, pkt[p], (p - 5) * 4, ulen);
         s = add_pseudo(s, pkt[3], pkt[4], pkt[2][23:16], ulen);
         csum = ~s[15:0];
         if (pd.mode == SUM_NONE)
            csum = 16'h0000;
         else if (pd.mode == SUM_BAD)
            csum = (csum == 16'h0000) ? 16'h5A5A : csum ^ 16'($urandom_range(1, 16'hFFFF));
         pkt[6][15:0] = csum;
      end
      typed_first = 32'h0;
      for (int i = 0; i < n; i++) begin
         // Only the first word decides the kind; later words may say anything.
         t = (i > 0 && pd.mix_type) ? 1'($urandom) : pd.is_reply;
         if (i == n - 1)
            typed_first = pd.typed_head;
         send_word(t, pkt[i], i == n - 1);
      end
      if (pd.typed_head != 0 && step_results != 5)
         report_mismatch("directed request gave no reply payload", 0, pd.typed_head);
      typed_first = 32'h0;
   endtask

   function automatic packet_desc_type random_packet(bit force_good);
      packet_desc_type pd;
      int r;
      r = $urandom_range(0, 99);
      pd.is_reply   = !force_good && (r < 40);
      pd.mix_type   = ($urandom_range(0, 9) == 0);
      pd.flags      = 8'($urandom);
      if ($urandom_range(0, 3) != 0)
         pd.flags[RESERVED_BIT] = 1'b0;
      pd.life       = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4000));
      pd.agent_sel  = $urandom_range(0, AGENT_SLOTS);
      pd.typed_head = 0;
      r = $urandom_range(0, 99);
      pd.mode = force_good ? SUM_GOOD : (r < 75) ? SUM_GOOD : (r < 85) ? SUM_BAD
              : (r < 93) ? SUM_NONE : SUM_ODD_LEN;
      if (pd.is_reply)
         pd.nwords = $urandom_range(1, 10);
      else if (!force_good && $urandom_range(0, 24) == 0)
         pd.nwords = $urandom_range(1, 12);
      else
         pd.nwords = $urandom_range(13, 16);
      return pd;
   endfunction

   task automatic random_traffic(int word_budget);
      int stop_at;
      stop_at = words_sent + word_budget;
      while (words_sent < stop_at)
         send_packet(random_packet(1'b0));
   endtask

   // Directed packets, run with the register values of reset: lifetime cap
   // 1800 and no home agent address valid.
   packet_desc_type directed_rows [] = '{
      // is_reply nwords flags   life      agent mode        mix   typed_head
      '{1'b1,     8,     8'h00,  16'h0000, 0,    SUM_GOOD,   1'b0, 32'h0},
      '{1'b0,     13,    8'h00,  16'hFFFF, 0,    SUM_GOOD,   1'b0, 32'h0388_0708},
      '{1'b0,     13,    8'h04,  16'h0005, 1,    SUM_GOOD,   1'b0, 32'h0386_0005},
      '{1'b0,     14,    8'hFB,  16'h0000, 0,    SUM_GOOD,   1'b0, 32'h0388_0000},
      '{1'b0,     13,    8'hFF,  16'h0708, 0,    SUM_GOOD,   1'b1, 32'h0386_0708},
      '{1'b0,     13,    8'h00,  16'h0010, 0,    SUM_BAD,    1'b0, 32'h0},
      '{1'b0,     15,    8'h00,  16'h0020, 0,    SUM_NONE,   1'b0, 32'h0},
      '{1'b0,     14,    8'h00,  16'h0030, 0,    SUM_ODD_LEN,1'b0, 32'h0},
      '{1'b0,     5,     8'h00,  16'h0000, 0,    SUM_GOOD,   1'b0, 32'h0},
      '{1'b1,     9,     8'h00,  16'h0000, 0,    SUM_GOOD,   1'b1, 32'h0},
      '{1'b1,     1,     8'h00,  16'h0000, 0,    SUM_GOOD,   1'b0, 32'h0},
      '{1'b1,     6,     8'h00,  16'h0000, 0,    SUM_GOOD,   1'b0, 32'h0}
   };

   // ---------------------------------------------------------------------
   // Clock and the free-running result receiver.
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   int rsp_hold;
   int rsp_free;

   initial begin
      rsp_hold = 0;
      rsp_free = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_free > 0) begin
            rsp_free--;
            rsp_ch.ready <= 1'b1;
         end else begin
            case ($urandom_range(0, 99)) inside
               [0:69]:  rsp_ch.ready <= 1'b1;
               [70:93]: begin rsp_ch.ready <= 1'b0; rsp_hold = $urandom_range(0, 2); end
               [94:97]: begin rsp_ch.ready <= 1'b0; rsp_hold = $urandom_range(10, 40); end
               default: begin rsp_ch.ready <= 1'b1; rsp_free = $urandom_range(30, 80); end
            endcase
         end
      end
   end

   // Every accepted result item is checked against the oldest expectation.
   always @(posedge clock) begin
      reply_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("result item with none expected", rsp_ch.out_word, 0);
         end else begin
            want = pending_replies[0];
            pending_replies.delete(0);
            if (rsp_ch.out_port !== want.port)
               report_mismatch("out_port", rsp_ch.out_port, want.port);
            if (rsp_ch.out_word !== want.word)
               report_mismatch("out_word", rsp_ch.out_word, want.word);
            if (rsp_ch.out_last !== want.last)
               report_mismatch("out_last", rsp_ch.out_last, want.last);
            if (rsp_ch.queue_fault !== want.fault)
               report_mismatch("queue_fault", rsp_ch.queue_fault, want.fault);
         end
      end
   end

   // Hard limit on the run, far beyond the slowest correct run.
   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      packet_desc_type pd;
      mismatches      = 0;
      words_sent      = 0;
      lifetime_cap    = LIFETIME_RESET;
      agents_valid    = 0;
      agent_addr      = '{default: 0};
      store_head      = 0;
      store_count     = 0;
      word_pos        = 0;
      udp_sum         = 0;
      pkt_is_reply    = 1'b0;
      reply_unmatched = 1'b0;
      typed_first     = 32'h0;
      step_results    = 0;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= 1'b0;
      req_ch.pkt_word <= '0;
      req_ch.pkt_last <= 1'b0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= '0;
      csr_ch.data     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_packet(directed_rows[i]);

      // Lowest lifetime cap with one agent; ignored writes past the list.
      // Fill the pending store to its depth, send one more request, which is
      // dropped, then drain the store with short replies.
      load_settings(16'd0, 3'd1, $urandom, $urandom, $urandom, $urandom);
      write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
      write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
      csr_ch.valid <= 1'b0;
      while (store_count < FIFO_DEPTH) begin
         pd = random_packet(1'b1);
         pd.nwords = 13;
         send_packet(pd);
      end
      pd = random_packet(1'b1);
      pd.nwords = 13;
      send_packet(pd);
      for (int i = 0; i < FIFO_DEPTH + 1; i++) begin
         pd = random_packet(1'b0);
         pd.is_reply = 1'b1;
         pd.nwords = $urandom_range(1, 2);
         send_packet(pd);
      end

      // Highest cap, all four agents, extreme addresses.
      load_settings(16'hFFFF, 3'd4, 32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom);
      random_traffic(20);

      // Agent count above the slot count saturates.
      load_settings(16'($urandom), 3'd7, $urandom, $urandom, $urandom, $urandom);
      random_traffic(15);
      // Hold the sender until every reply is out, then carry on.
      wait_quiet();
      random_traffic(15);

      wait_quiet();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
